[src/nbm_pkg.sv]
`default_nettype none
package nbm_pkg;

  localparam int NUM_STATES_DEF = 32;
  localparam int NUM_SLOTS_DEF  = 16;

  localparam int KIND_W   = 2;
  localparam int STIDX_W  = 5;
  localparam int SLOT_W   = 4;
  localparam int MASK_W   = 32;
  localparam int CHAR_W   = 8;
  localparam int SYMCNT_W = 4;
  localparam int CFG_IW   = 1;
  localparam int CFG_DW   = 32;

  localparam logic [CHAR_W-1:0] EPS_CHAR = 8'h30;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_TRANS = 2'd0,
    KIND_LOAD_CHAR  = 2'd1,
    KIND_START      = 2'd2,
    KIND_SYMBOL     = 2'd3
  } kind_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ACCEPTING = 1'd0,
    CFG_SYMCOUNT  = 1'd1
  } cfg_idx_t;

endpackage
`default_nettype wire

[src/nbm_ifs.sv]
`default_nettype none
interface nbm_in_if import nbm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  kind_t                kind;
  logic [STIDX_W-1:0]   state_index;
  logic [SLOT_W-1:0]    slot;
  logic [MASK_W-1:0]    next_states;
  logic [CHAR_W-1:0]    char_code;
  modport source (output valid, kind, state_index, slot, next_states, char_code,
                  input ready);
  modport sink   (input valid, kind, state_index, slot, next_states, char_code,
                  output ready);
endinterface

interface nbm_out_if import nbm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic                 invalid_symbol;
  logic [MASK_W-1:0]    active_states;
  modport source (output valid, accepted, invalid_symbol, active_states, input ready);
  modport sink   (input valid, accepted, invalid_symbol, active_states, output ready);
endinterface

interface nbm_cfg_if import nbm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  cfg_idx_t             index;
  logic [CFG_DW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/nbm_ram.sv]
`default_nettype none
module nbm_ram import nbm_pkg::*; #(
  parameter int DEPTH = NUM_STATES_DEF * NUM_SLOTS_DEF,
  parameter int WIDTH = NUM_STATES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

[src/nbm_engine.sv]
`default_nettype none
module nbm_engine import nbm_pkg::*; #(
  parameter int NUM_STATES = NUM_STATES_DEF,
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  localparam int DEPTH = NUM_STATES * NUM_SLOTS,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  nbm_in_if.sink                     in_ch,
  nbm_out_if.source                  out_ch,
  input  wire logic [MASK_W-1:0]     accepting,
  input  wire logic [SYMCNT_W-1:0]   symbol_count,
  output logic                       wr_en,
  output logic      [AW-1:0]         wr_addr,
  output logic      [NUM_STATES-1:0] wr_data,
  output logic      [AW-1:0]         rd_addr,
  input  wire logic [NUM_STATES-1:0] rd_data
);
  localparam int NS  = NUM_STATES;
  localparam int NSL = NUM_SLOTS;
  localparam int STW = $clog2(NS);
  localparam int SW  = $clog2(NSL);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_SEARCH, S_CLOSE, S_APPLY, S_APPLY_END, S_REPORT
  } st_t;

  st_t               state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [STW-1:0]    idx_r, idx_nxt;
  logic [SW-1:0]     j_r, j_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic [NS-1:0]     set_r, set_nxt;
  logic [NS-1:0]     pend_r, pend_nxt;
  logic [NS-1:0]     acc_r, acc_nxt;
  logic              take_r, take_nxt;
  logic              apply_r, apply_nxt;
  logic              inv_r, inv_nxt;
  logic [CHAR_W-1:0] alpha_r [NSL];
  logic [CHAR_W-1:0] alpha_nxt [NSL];
  logic              ov_r, ov_nxt;
  logic              oacc_r, oacc_nxt;
  logic              oinv_r, oinv_nxt;
  logic [MASK_W-1:0] oset_r, oset_nxt;

  logic [NS-1:0]     load_mask;
  logic [NS-1:0]     acc_mask;
  logic [MASK_W-1:0] set_out;
  logic [STW-1:0]    idx_wrap;
  int                lim;

  if (NS >= MASK_W) begin : g_wide
    assign load_mask = NS'(in_ch.next_states);
    assign acc_mask  = NS'(accepting);
    assign set_out   = set_r[MASK_W-1:0];
  end else begin : g_narrow
    assign load_mask = in_ch.next_states[NS-1:0];
    assign acc_mask  = accepting[NS-1:0];
    assign set_out   = MASK_W'(set_r);
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = ov_r;
  assign out_ch.accepted       = oacc_r;
  assign out_ch.invalid_symbol = oinv_r;
  assign out_ch.active_states  = oset_r;

  assign idx_wrap = (idx_r == STW'(NS - 1)) ? '0 : idx_r + STW'(1);
  assign lim = (int'(symbol_count) < NSL - 1) ? int'(symbol_count) : NSL - 1;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    idx_nxt   = idx_r;
    j_nxt     = j_r;
    slot_nxt  = slot_r;
    ch_nxt    = ch_r;
    set_nxt   = set_r;
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    take_nxt  = 1'b0;
    apply_nxt = apply_r;
    inv_nxt   = inv_r;
    alpha_nxt = alpha_r;
    oacc_nxt  = oacc_r;
    oinv_nxt  = oinv_r;
    oset_nxt  = oset_r;
    ov_nxt    = ov_r && !out_ch.ready;
    wr_en     = 1'b0;
    wr_addr   = AW'(STW'(in_ch.state_index)) * AW'(NSL) + AW'(SW'(in_ch.slot));
    wr_data   = load_mask;
    rd_addr   = AW'(idx_r) * AW'(NSL);

    case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.kind)
            KIND_LOAD_TRANS: begin
              wr_en = (int'(in_ch.state_index) < NS) && (int'(in_ch.slot) < NSL);
            end
            KIND_LOAD_CHAR: begin
              if (in_ch.slot != '0 && int'(in_ch.slot) < NSL) begin
                alpha_nxt[SW'(in_ch.slot)] = in_ch.char_code;
              end
            end
            KIND_START: begin
              set_nxt   = NS'(1);
              pend_nxt  = NS'(1);
              idx_nxt   = '0;
              apply_nxt = 1'b0;
              inv_nxt   = 1'b0;
              state_nxt = S_CLOSE;
            end
            default: begin
              ch_nxt    = in_ch.char_code;
              j_nxt     = '0;
              state_nxt = S_SEARCH;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (alpha_r[j_r] == ch_r) begin
          slot_nxt  = j_r;
          pend_nxt  = set_r;
          idx_nxt   = '0;
          apply_nxt = 1'b1;
          inv_nxt   = 1'b0;
          state_nxt = S_CLOSE;
        end else if (int'(j_r) >= lim) begin
          inv_nxt   = 1'b1;
          state_nxt = S_REPORT;
        end else begin
          j_nxt = j_r + SW'(1);
        end
      end
      S_CLOSE: begin
        if (!take_r && pend_r == '0) begin
          idx_nxt = '0;
          if (apply_r) begin
            acc_nxt   = '0;
            state_nxt = S_APPLY;
          end else begin
            state_nxt = S_REPORT;
          end
        end else begin
          take_nxt = pend_r[idx_r];
          pend_nxt[idx_r] = 1'b0;
          if (take_r) begin
            pend_nxt = pend_nxt | (rd_data & ~set_r);
            set_nxt  = set_r | rd_data;
          end
          idx_nxt = idx_wrap;
        end
      end
      S_APPLY: begin
        rd_addr  = AW'(idx_r) * AW'(NSL) + AW'(slot_r);
        take_nxt = set_r[idx_r];
        if (take_r) begin
          acc_nxt = acc_r | rd_data;
        end
        idx_nxt = idx_wrap;
        if (idx_r == STW'(NS - 1)) begin
          state_nxt = S_APPLY_END;
        end
      end
      S_APPLY_END: begin
        set_nxt   = take_r ? (acc_r | rd_data) : acc_r;
        pend_nxt  = set_nxt;
        idx_nxt   = '0;
        apply_nxt = 1'b0;
        state_nxt = S_CLOSE;
      end
      S_REPORT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          oacc_nxt  = |(set_r & acc_mask);
          oinv_nxt  = inv_r;
          oset_nxt  = set_out;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      take_r  <= 1'b0;
      ov_r    <= 1'b0;
      set_r   <= '0;
      for (int k = 0; k < NSL; k++) begin
        alpha_r[k] <= (k == 0) ? EPS_CHAR : '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      take_r  <= take_nxt;
      ov_r    <= ov_nxt;
      set_r   <= set_nxt;
      alpha_r <= alpha_nxt;
    end
    idx_r   <= idx_nxt;
    j_r     <= j_nxt;
    slot_r  <= slot_nxt;
    ch_r    <= ch_nxt;
    pend_r  <= pend_nxt;
    acc_r   <= acc_nxt;
    apply_r <= apply_nxt;
    inv_r   <= inv_nxt;
    oacc_r  <= oacc_nxt;
    oinv_r  <= oinv_nxt;
    oset_r  <= oset_nxt;
  end
endmodule
`default_nettype wire

[src/nfa_bitset_matcher.sv]
// NFA matcher with the active state set kept as a bit vector.
// in_ch takes requests: transition loads, alphabet loads, start and symbol.
// Loads finish in the cycle they are accepted and produce no result.
// Start and symbol requests each produce one result request on out_ch.
// cfg_ch writes accepting_states (index 0) and symbol_count (index 1); always ready.
// Epsilon closure scans the states in a ring, one transition row read a cycle;
// a state reached behind the scan point waits for the next lap.
// Start: one closure, then a report.
// Symbol: an alphabet search over slots 0 to symbol_count (at most NUM_SLOTS-1),
// then a closure, a pass over the symbol's rows and a second closure; a symbol
// not found in the search goes straight to a report with invalid_symbol set.
// One request is worked on at a time; the result sits in an output
// register, and a stalled receiver holds back only the next result.
// After reset a clearing pass zeroes all NUM_STATES*NUM_SLOTS words of the
// transition RAM; in_ch is not ready during it.
`default_nettype none
module nfa_bitset_matcher import nbm_pkg::*; #(
  parameter int NUM_STATES = NUM_STATES_DEF,
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  nbm_in_if.sink      in_ch,
  nbm_out_if.source   out_ch,
  nbm_cfg_if.sink     cfg_ch
);
  localparam int DEPTH = NUM_STATES * NUM_SLOTS;
  localparam int AW    = $clog2(DEPTH);

  logic [MASK_W-1:0]     accepting_r;
  logic [SYMCNT_W-1:0]   symcnt_r;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [NUM_STATES-1:0] wr_data;
  logic [AW-1:0]         rd_addr;
  logic [NUM_STATES-1:0] rd_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accepting_r <= '0;
      symcnt_r    <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_ACCEPTING: accepting_r <= cfg_ch.data;
        CFG_SYMCOUNT:  symcnt_r    <= cfg_ch.data[SYMCNT_W-1:0];
        default: ;
      endcase
    end
  end

  nbm_engine #(.NUM_STATES(NUM_STATES), .NUM_SLOTS(NUM_SLOTS)) u_engine (
    .clk, .rst_n, .in_ch, .out_ch,
    .accepting(accepting_r), .symbol_count(symcnt_r),
    .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );

  nbm_ram #(.DEPTH(DEPTH), .WIDTH(NUM_STATES)) u_ram (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );
endmodule
`default_nettype wire
